/* rtl/core/cva_pkg.sv */
package cva_pkg;

  localparam int IN_W            = 16;
  localparam int ANGLE_W         = 16;
  localparam int PRESCALE_SHIFT  = 10;
  localparam int DATA_W          = 28;
  localparam int ITERATIONS      = 15;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int TABLE_LEN       = 15;
  localparam int TABLE_FRAC      = 30;
  localparam int IDX_W           = $clog2(TABLE_LEN);

  // atan(2^-i) at 2^30 scale
  localparam logic [31:0] ATAN_Q30 [TABLE_LEN] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515,  32'd16775850,  32'd8388437,   32'd4194282,   32'd2097149,
    32'd1048575,   32'd524287,    32'd262143,    32'd131071,    32'd65535
  };

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic [ANGLE_W-1:0]       sum;
  } cva_item_t;

  // Step angle for rotation idx, truncated to the output scale.
  function automatic logic [ANGLE_W-1:0] step_angle(input logic [IDX_W-1:0] idx);
    logic [31:0] v;
    v = ATAN_Q30[idx] >> (TABLE_FRAC - ANGLE_FRAC_BITS);
    return v[ANGLE_W-1:0];
  endfunction

endpackage

/* rtl/core/cva_cell.sv */
module cva_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cva_pkg::IDX_W-1:0] stage_idx,
  input  logic                      up_valid,
  input  cva_pkg::cva_item_t        up_item,
  output logic                      up_ready,
  output logic                      valid,
  output cva_pkg::cva_item_t        item,
  input  logic                      down_ready
);
  import cva_pkg::*;

  logic signed [DATA_W-1:0] xs;
  logic signed [DATA_W-1:0] ys;
  logic                     y_pos;
  cva_item_t                item_next;

  assign up_ready = !valid || down_ready;

  // Rotate toward y = 0; y of zero counts as non-positive.
  always_comb begin
    xs    = up_item.x >>> stage_idx;
    ys    = up_item.y >>> stage_idx;
    y_pos = !up_item.y[DATA_W-1] && (up_item.y != '0);
    if (y_pos) begin
      item_next.x   = up_item.x + ys;
      item_next.y   = up_item.y - xs;
      item_next.sum = up_item.sum + step_angle(stage_idx);
    end else begin
      item_next.x   = up_item.x - ys;
      item_next.y   = up_item.y + xs;
      item_next.sum = up_item.sum - step_angle(stage_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/core/cordic_vector_angle.sv */
// CORDIC vectoring-mode angle of a signed (x, y) vector.
// Stages: ITERATIONS (15) register stages; the angle is the sum held in the last cell.
// Throughput: one item per cycle while angle_stall is low; one pipeline cell per rotation, and each cell
//   holds its item until the next cell frees, so stalls only back up full cells.
// Reset: rst clears every cell's valid bit; in-flight items are dropped.
module cordic_vector_angle (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [cva_pkg::IN_W-1:0]   x_component,
  input  logic signed [cva_pkg::IN_W-1:0]   y_component,
  input  logic                              vec_valid,
  output logic                              vec_stall,
  output logic signed [cva_pkg::ANGLE_W-1:0] angle,
  output logic                              angle_valid,
  input  logic                              angle_stall
);
  import cva_pkg::*;

  // Chain links: entry k feeds cell k, entry ITERATIONS is the pipeline output.
  cva_item_t chain_item  [ITERATIONS+1];
  logic      chain_valid [ITERATIONS+1];
  logic      chain_ready [ITERATIONS+1];

  // Prescale by 1024 into the wide datapath, start with a zero angle sum.
  assign chain_valid[0]    = vec_valid;
  assign chain_item[0].x   = {{(DATA_W-IN_W-PRESCALE_SHIFT){x_component[IN_W-1]}},
                              x_component, {PRESCALE_SHIFT{1'b0}}};
  assign chain_item[0].y   = {{(DATA_W-IN_W-PRESCALE_SHIFT){y_component[IN_W-1]}},
                              y_component, {PRESCALE_SHIFT{1'b0}}};
  assign chain_item[0].sum = '0;
  assign vec_stall         = !chain_ready[0];

  // One cell per rotation; the stage number selects shift and step angle.
  for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
    cva_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .stage_idx  (IDX_W'(k)),
      .up_valid   (chain_valid[k]),
      .up_item    (chain_item[k]),
      .up_ready   (chain_ready[k]),
      .valid      (chain_valid[k+1]),
      .item       (chain_item[k+1]),
      .down_ready (chain_ready[k+1])
    );
  end

  // Last cell doubles as the output register.
  assign chain_ready[ITERATIONS] = !angle_stall;
  assign angle_valid             = chain_valid[ITERATIONS];
  assign angle                   = chain_item[ITERATIONS].sum;

  // A free-running output never pushes back on the input.
  a_no_stall_through: assert property (@(posedge clk) disable iff (rst)
    !angle_stall |-> !vec_stall)
    else $error("input stalled while output is free");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !angle_valid)
    else $error("result valid right after reset");

  // Input back-pressure only once the first cell is full and cannot drain.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    vec_stall |-> (chain_valid[1] && !chain_ready[1]))
    else $error("input stalled with first cell free");

endmodule
